[design/grid_disk_collision_check_macros.svh]
// Assertion macros for the collision checker.
`ifndef GRID_DISK_COLLISION_CHECK_MACROS_SVH
`define GRID_DISK_COLLISION_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// Flag any cycle in which cond holds.
`define GDCC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: condition must never hold");
// a in a cycle requires b in the same cycle.
`define GDCC_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: implication broken");
// a in a cycle requires b in the next cycle.
`define GDCC_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication broken");
`else
`define GDCC_NEVER(lbl, clk, rst_n, cond)
`define GDCC_IMPLY(lbl, clk, rst_n, a, b)
`define GDCC_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

[design/gdcc_pkg.sv]
package gdcc_pkg;

	localparam int MAX_DIM    = 256;
	localparam int MAX_RADIUS = 16;
	localparam int FRAC_BITS  = 8;

	localparam int DIM_W    = $clog2(MAX_DIM);
	localparam int ADDR_W   = 2 * DIM_W;
	localparam int DEPTH    = MAX_DIM * MAX_DIM;
	localparam int CELL_W   = 8;
	localparam int SIZE_W   = 9;
	localparam int RAD_W    = 13;
	localparam int Q_W      = 17;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 2;

	localparam int ONE      = 1 << FRAC_BITS;
	localparam int HALF     = 1 << (FRAC_BITS - 1);
	localparam int RAD_MAX  = MAX_RADIUS << FRAC_BITS;

	// scan offset 0..MAX_RADIUS, counter 0..2*MAX_RADIUS
	localparam int OFF_W    = $clog2(MAX_RADIUS + 1);
	localparam int CNT_W    = OFF_W + 1;
	// query position plus centre shift
	localparam int POS_W    = Q_W + 1;
	// signed cell index including scan offset
	localparam int CPOS_W   = POS_W - FRAC_BITS + 1;
	// distance to a cell centre, and its square
	localparam int SQ_IN_W  = FRAC_BITS + OFF_W + 1;
	localparam int SQ_OUT_W = 2 * SQ_IN_W - 3;

	localparam logic [IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [IDX_W-1:0] REG_RAD  = 2'd2;
	localparam logic [IDX_W-1:0] REG_THR  = 2'd3;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic             prep;
		logic             row_step;
		logic             col_step;
		logic             drain;
		logic [CNT_W-1:0] i;
		logic [CNT_W-1:0] j;
	} gdcc_ctl_t;

endpackage

[design/gdcc_ram.sv]
module gdcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/gdcc_sqr.sv]
module gdcc_sqr (
	input  logic signed [gdcc_pkg::SQ_IN_W-1:0] a,
	output logic        [gdcc_pkg::SQ_OUT_W-1:0] sq
);

	logic signed [2*gdcc_pkg::SQ_IN_W-1:0] prod;

	// operands stay small enough that the square fits the output
	assign prod = a * a;
	assign sq   = prod[gdcc_pkg::SQ_OUT_W-1:0];

endmodule

[design/gdcc_seq.sv]
module gdcc_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [gdcc_pkg::OFF_W-1:0]   off,
	output gdcc_pkg::gdcc_ctl_t          ctl,
	output logic                         busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_ROW   = 3'd2;
	localparam logic [2:0] S_COL   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;

	logic [2:0]                   state_q;
	logic [gdcc_pkg::CNT_W-1:0]   i_q;
	logic [gdcc_pkg::CNT_W-1:0]   j_q;
	logic [gdcc_pkg::CNT_W-1:0]   span;

	assign span = {off, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) state_q <= S_PREP;
				end
				S_PREP: begin
					i_q     <= '0;
					state_q <= S_ROW;
				end
				S_ROW: begin
					j_q     <= '0;
					state_q <= S_COL;
				end
				S_COL: begin
					if (j_q == span) begin
						if (i_q == span) begin
							state_q <= S_DRAIN;
						end else begin
							i_q     <= i_q + gdcc_pkg::CNT_W'(1);
							state_q <= S_ROW;
						end
					end else begin
						j_q <= j_q + gdcc_pkg::CNT_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.prep     = (state_q == S_PREP);
		ctl.row_step = (state_q == S_ROW);
		ctl.col_step = (state_q == S_COL);
		ctl.drain    = (state_q == S_DRAIN);
		ctl.i        = i_q;
		ctl.j        = j_q;
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/grid_disk_collision_check.sv]
// Channel   Handshake        Payload
// ------    ---------        -------
// item in   start / busy     mode, cell_row, cell_col, cell_value, query_x, query_y
// result    done (strobe)    is_clear
// config    cfg_we           cfg_index, cfg_data
//
// A write beat is taken at once: busy stays low and no result follows.
// A query beat holds busy high through set-up, then for each of 2*off+1 rows a row
// step and a scan of 2*off+1 cells, then a drain; off is the radius rounded up to
// whole cells (8 at the reset radius). done pulses in the cycle after the drain. The
// scan reads one cell per cycle within a row through the single read port of the map RAM.
// Reset loads config defaults and clears the sequencer; the map RAM holds garbage
// until written. The receiver cannot stall: each result is on the ports for one cycle.
`include "grid_disk_collision_check_macros.svh"

module grid_disk_collision_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic [gdcc_pkg::DIM_W-1:0]          cell_row,
	input  logic [gdcc_pkg::DIM_W-1:0]          cell_col,
	input  logic signed [gdcc_pkg::CELL_W-1:0]  cell_value,
	input  logic signed [gdcc_pkg::Q_W-1:0]     query_x,
	input  logic signed [gdcc_pkg::Q_W-1:0]     query_y,
	output logic                                done,
	output logic                                is_clear,
	input  logic                                cfg_we,
	input  logic [gdcc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [gdcc_pkg::CFG_W-1:0]          cfg_data
);

	// Round a fixed-point position to the nearest cell, halves away from zero.
	function automatic logic signed [gdcc_pkg::CPOS_W-1:0] round_cell(
		input logic signed [gdcc_pkg::POS_W-1:0] p
	);
		logic [gdcc_pkg::POS_W-1:0]          mag;
		logic [gdcc_pkg::POS_W-1:0]          m;
		logic signed [gdcc_pkg::CPOS_W-1:0]  m_s;
		mag = p[gdcc_pkg::POS_W-1] ? gdcc_pkg::POS_W'(-p) : gdcc_pkg::POS_W'(p);
		m   = (mag + gdcc_pkg::POS_W'(gdcc_pkg::HALF)) >> gdcc_pkg::FRAC_BITS;
		m_s = $signed(gdcc_pkg::CPOS_W'(m));
		round_cell = p[gdcc_pkg::POS_W-1] ? -m_s : m_s;
	endfunction

	// configuration registers
	logic [gdcc_pkg::SIZE_W-1:0]         rows_q;
	logic [gdcc_pkg::SIZE_W-1:0]         cols_q;
	logic [gdcc_pkg::RAD_W-1:0]          rad_q;
	logic signed [gdcc_pkg::CELL_W-1:0]  thr_q;

	// query set-up
	logic signed [gdcc_pkg::Q_W-1:0]     qx_q;
	logic signed [gdcc_pkg::Q_W-1:0]     qy_q;
	logic signed [gdcc_pkg::POS_W-1:0]   px_q;
	logic signed [gdcc_pkg::POS_W-1:0]   py_q;
	logic signed [gdcc_pkg::CPOS_W-1:0]  row_q;
	logic signed [gdcc_pkg::CPOS_W-1:0]  col_q;
	logic [gdcc_pkg::OFF_W-1:0]          off_q;
	logic [gdcc_pkg::SQ_OUT_W-1:0]       r2_q;

	// scan row state and first scan stage
	logic [gdcc_pkg::SQ_OUT_W-1:0]       dx2_q;
	logic                                rowin_q;
	logic [gdcc_pkg::DIM_W-1:0]          row_addr_q;
	logic                                v_s1;
	logic [gdcc_pkg::SQ_OUT_W-1:0]       sq_s1;

	// verdict
	logic                                clear_q;
	logic                                done_q;
	logic                                is_clear_q;

	gdcc_pkg::gdcc_ctl_t                 ctl;

	logic                                accept;
	logic                                go;
	logic                                wr_cell;
	logic [gdcc_pkg::SIZE_W-1:0]         rows_eff;
	logic [gdcc_pkg::SIZE_W-1:0]         cols_eff;
	logic [gdcc_pkg::DIM_W-1:0]          rows_m1;
	logic [gdcc_pkg::DIM_W-1:0]          cols_m1;
	logic signed [gdcc_pkg::POS_W-1:0]   px_d;
	logic signed [gdcc_pkg::POS_W-1:0]   py_d;
	logic [gdcc_pkg::RAD_W-1:0]          rad_c;
	logic [gdcc_pkg::RAD_W:0]            rad_up;
	logic [gdcc_pkg::OFF_W-1:0]          off_d;

	logic signed [gdcc_pkg::CNT_W:0]     oi;
	logic signed [gdcc_pkg::CNT_W:0]     oj;
	logic signed [gdcc_pkg::CPOS_W-1:0]  r_cell;
	logic signed [gdcc_pkg::CPOS_W-1:0]  c_cell;
	logic signed [gdcc_pkg::CPOS_W+gdcc_pkg::FRAC_BITS-1:0] dx_full;
	logic signed [gdcc_pkg::CPOS_W+gdcc_pkg::FRAC_BITS-1:0] dy_full;
	logic                                rowin_d;
	logic                                colin_d;

	logic signed [gdcc_pkg::SQ_IN_W-1:0] sq_a;
	logic [gdcc_pkg::SQ_OUT_W-1:0]       sq_out;

	logic [gdcc_pkg::ADDR_W-1:0]         raddr;
	logic [gdcc_pkg::CELL_W-1:0]         rdata;
	logic [gdcc_pkg::SQ_OUT_W:0]         dist2;
	logic                                hit;

	assign accept  = start && !busy;
	assign go      = accept && (mode == gdcc_pkg::MODE_QUERY);
	assign wr_cell = accept && (mode == gdcc_pkg::MODE_WRITE);

	// Register writes land straight away; software must write only while idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM);
			cols_q <= gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM);
			rad_q  <= gdcc_pkg::RAD_W'(2048);
			thr_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdcc_pkg::REG_ROWS: rows_q <= cfg_data[gdcc_pkg::SIZE_W-1:0];
				gdcc_pkg::REG_COLS: cols_q <= cfg_data[gdcc_pkg::SIZE_W-1:0];
				gdcc_pkg::REG_RAD:  rad_q  <= cfg_data[gdcc_pkg::RAD_W-1:0];
				gdcc_pkg::REG_THR:  thr_q  <= $signed(cfg_data[gdcc_pkg::CELL_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// Clamp the map size to 1..MAX_DIM and the radius to MAX_RADIUS cells.
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = gdcc_pkg::SIZE_W'(1);
		end else if (rows_q > gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM)) begin
			rows_eff = gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == '0) begin
			cols_eff = gdcc_pkg::SIZE_W'(1);
		end else if (cols_q > gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM)) begin
			cols_eff = gdcc_pkg::SIZE_W'(gdcc_pkg::MAX_DIM);
		end else begin
			cols_eff = cols_q;
		end
		if (rad_q > gdcc_pkg::RAD_W'(gdcc_pkg::RAD_MAX)) begin
			rad_c = gdcc_pkg::RAD_W'(gdcc_pkg::RAD_MAX);
		end else begin
			rad_c = rad_q;
		end
	end

	assign rows_m1 = gdcc_pkg::DIM_W'(rows_eff - gdcc_pkg::SIZE_W'(1));
	assign cols_m1 = gdcc_pkg::DIM_W'(cols_eff - gdcc_pkg::SIZE_W'(1));

	// Shift the query from centre-relative to map coordinates: add (size-1)/2 cells.
	assign px_d = gdcc_pkg::POS_W'(qx_q)
		+ $signed(gdcc_pkg::POS_W'({rows_m1, {(gdcc_pkg::FRAC_BITS-1){1'b0}}}));
	assign py_d = gdcc_pkg::POS_W'(qy_q)
		+ $signed(gdcc_pkg::POS_W'({cols_m1, {(gdcc_pkg::FRAC_BITS-1){1'b0}}}));

	// Scan half-width: ceiling of the radius in whole cells.
	assign rad_up = (gdcc_pkg::RAD_W+1)'(rad_c) + (gdcc_pkg::RAD_W+1)'(gdcc_pkg::ONE - 1);
	assign off_d  = rad_up[gdcc_pkg::FRAC_BITS +: gdcc_pkg::OFF_W];

	// Cell under the scan: centre cell plus counter minus half-width.
	assign oi = $signed({1'b0, ctl.i}) - $signed((gdcc_pkg::CNT_W+1)'(off_q));
	assign oj = $signed({1'b0, ctl.j}) - $signed((gdcc_pkg::CNT_W+1)'(off_q));
	assign r_cell = row_q + gdcc_pkg::CPOS_W'(oi);
	assign c_cell = col_q + gdcc_pkg::CPOS_W'(oj);

	// Distance from the query point to that cell centre, in fixed point.
	assign dx_full = $signed({r_cell, {gdcc_pkg::FRAC_BITS{1'b0}}})
		- (gdcc_pkg::CPOS_W+gdcc_pkg::FRAC_BITS)'(px_q);
	assign dy_full = $signed({c_cell, {gdcc_pkg::FRAC_BITS{1'b0}}})
		- (gdcc_pkg::CPOS_W+gdcc_pkg::FRAC_BITS)'(py_q);

	assign rowin_d = !r_cell[gdcc_pkg::CPOS_W-1]
		&& ($unsigned(r_cell) < gdcc_pkg::CPOS_W'(rows_eff));
	assign colin_d = !c_cell[gdcc_pkg::CPOS_W-1]
		&& ($unsigned(c_cell) < gdcc_pkg::CPOS_W'(cols_eff));

	// The one squarer: radius during set-up, row distance once per row,
	// column distance once per cell.
	always_comb begin
		if (ctl.prep) begin
			sq_a = $signed(gdcc_pkg::SQ_IN_W'(rad_c));
		end else if (ctl.row_step) begin
			sq_a = dx_full[gdcc_pkg::SQ_IN_W-1:0];
		end else begin
			sq_a = dy_full[gdcc_pkg::SQ_IN_W-1:0];
		end
	end

	gdcc_sqr u_sqr (
		.a  (sq_a),
		.sq (sq_out)
	);

	gdcc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.off    (off_q),
		.ctl    (ctl),
		.busy   (busy)
	);

	assign raddr = {row_addr_q, c_cell[gdcc_pkg::DIM_W-1:0]};

	gdcc_ram #(
		.WIDTH (gdcc_pkg::CELL_W),
		.DEPTH (gdcc_pkg::DEPTH)
	) u_map (
		.clk   (clk),
		.we    (wr_cell),
		.waddr ({cell_row, cell_col}),
		.wdata (cell_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Second scan stage: map data is back; test footprint and occupancy together.
	assign dist2 = (gdcc_pkg::SQ_OUT_W+1)'(dx2_q) + (gdcc_pkg::SQ_OUT_W+1)'(sq_s1);
	assign hit   = v_s1 && (dist2 < (gdcc_pkg::SQ_OUT_W+1)'(r2_q))
		&& ($signed(rdata) > thr_q);

	// Latch the query, then hold set-up and per-row values for the scan.
	always_ff @(posedge clk) begin
		if (go) begin
			qx_q <= query_x;
			qy_q <= query_y;
		end
		if (ctl.prep) begin
			px_q  <= px_d;
			py_q  <= py_d;
			row_q <= round_cell(px_d);
			col_q <= round_cell(py_d);
			off_q <= off_d;
			r2_q  <= sq_out;
		end
		if (ctl.row_step) begin
			dx2_q      <= sq_out;
			rowin_q    <= rowin_d;
			row_addr_q <= r_cell[gdcc_pkg::DIM_W-1:0];
		end
		if (ctl.col_step) begin
			sq_s1 <= sq_out;
		end
	end

	// Cells off the map never reach the compare: drop them at the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			clear_q    <= 1'b1;
			done_q     <= 1'b0;
			is_clear_q <= 1'b1;
		end else begin
			v_s1   <= ctl.col_step && rowin_q && colin_d;
			done_q <= ctl.drain;
			if (ctl.prep) begin
				clear_q <= 1'b1;
			end else if (hit) begin
				clear_q <= 1'b0;
			end
			if (ctl.drain) begin
				is_clear_q <= clear_q && !hit;
			end
		end
	end

	assign done     = done_q;
	assign is_clear = is_clear_q;

	// A result beat never overlaps a running scan.
	`GDCC_NEVER(a_done_idle, clk, arst_n, done && busy)
	// A query beat starts the scan at once and gives no result in the next cycle.
	`GDCC_NEXT(a_query_busy, clk, arst_n, start && !busy && mode, busy && !done)
	// A write beat leaves the block ready.
	`GDCC_NEXT(a_write_idle, clk, arst_n, start && !busy && !mode, !busy && !done)
	// A result only follows a scan.
	`GDCC_IMPLY(a_done_after_scan, clk, arst_n, done, $past(busy))

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import gdcc_pkg::*;

	// Run shape: a first-pass fill of the whole map, a short directed table, then
	// random phases, each under its own register setting.
	localparam int N_PHASES       = 10;
	localparam int BIG_RAD_PHASE  = 8;
	localparam int PHASE_BEATS    = 220;
	localparam int BIG_RAD_BEATS  = 60;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int MAX_REPORTS    = 20;

	// Directed rows either move one beat or write one register.
	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;
	// How a query's verdict is known: from the predictor, or typed into the row.
	typedef enum logic [1:0] {EXP_PREDICT, EXP_CLEAR, EXP_BLOCKED} verdict_src_e;

	typedef struct packed {
		logic              mode;
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic [CELL_W-1:0] value;
		logic [Q_W-1:0]    qx;
		logic [Q_W-1:0]    qy;
	} grid_beat_t;

	typedef struct packed {
		row_kind_e         kind;
		grid_beat_t        beat;
		verdict_src_e      how;
		logic [IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]  reg_val;
	} directed_row_t;

	typedef struct packed {
		logic        is_clear;
		logic [31:0] query_no;
	} clear_verdict_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     mode       = MODE_WRITE;
	logic [DIM_W-1:0]         cell_row   = '0;
	logic [DIM_W-1:0]         cell_col   = '0;
	logic signed [CELL_W-1:0] cell_value = '0;
	logic signed [Q_W-1:0]    query_x    = '0;
	logic signed [Q_W-1:0]    query_y    = '0;
	logic                     cfg_we     = 1'b0;
	logic [IDX_W-1:0]         cfg_index  = '0;
	logic [CFG_W-1:0]         cfg_data   = '0;
	logic                     busy;
	logic                     done;
	logic                     is_clear;

	// Shadow copy of the block's state: registers start at their reset values,
	// the map is fully written before the first query.
	logic [SIZE_W-1:0]        rows_reg = SIZE_W'(MAX_DIM);
	logic [SIZE_W-1:0]        cols_reg = SIZE_W'(MAX_DIM);
	logic [RAD_W-1:0]         rad_reg  = RAD_W'(2048);
	logic signed [CELL_W-1:0] thr_reg  = '0;
	logic signed [CELL_W-1:0] grid_shadow [DEPTH];

	clear_verdict_t clear_verdicts_due[$];
	directed_row_t  directed_rows[$];

	int unsigned n_map_writes = 0;
	int unsigned n_queries    = 0;
	int unsigned n_clear      = 0;
	int unsigned n_blocked    = 0;
	int unsigned n_reg_writes = 0;
	int unsigned n_mismatch   = 0;

	grid_disk_collision_check u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_value (cell_value),
		.query_x    (query_x),
		.query_y    (query_y),
		.done       (done),
		.is_clear   (is_clear),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Map size as the block uses it: zero acts as one, anything above MAX_DIM saturates.
	function automatic longint dim_in_use(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	// Nearest whole cell of a fixed-point position, halves away from zero.
	function automatic longint nearest_cell(input longint p);
		if (p >= 0)
			return (p + HALF) / ONE;
		return -((-p + HALF) / ONE);
	endfunction

	// Scan the square of cells around the rounded query point; a cell counts when its
	// centre lies strictly inside the radius, compared as squares at 2*FRAC_BITS.
	function automatic logic predict_clear(input logic signed [Q_W-1:0] qx,
	                                       input logic signed [Q_W-1:0] qy);
		longint rows_n, cols_n, rad, thr, px, py, row_c, col_c, off, r2;
		longint i, j, r, c, dx, dy, occ;
		rows_n = dim_in_use(rows_reg);
		cols_n = dim_in_use(cols_reg);
		rad    = rad_reg;
		if (rad > RAD_MAX)
			rad = RAD_MAX;
		thr    = thr_reg;
		px     = qx;
		py     = qy;
		// shift from centre-relative to map-relative: (size-1)/2 cells
		px     = px + (rows_n - 1) * HALF;
		py     = py + (cols_n - 1) * HALF;
		row_c  = nearest_cell(px);
		col_c  = nearest_cell(py);
		off    = (rad + ONE - 1) / ONE;
		r2     = rad * rad;
		for (i = -off; i <= off; i++) begin
			r = row_c + i;
			if (r < 0 || r >= rows_n)
				continue;
			dx = r * ONE - px;
			for (j = -off; j <= off; j++) begin
				c = col_c + j;
				if (c < 0 || c >= cols_n)
					continue;
				dy  = c * ONE - py;
				occ = grid_shadow[r * MAX_DIM + c];
				if (dx * dx + dy * dy < r2 && occ > thr)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Present one beat and hold it until the block takes it, then update the shadow
	// map or queue the verdict. Start is left high so back-to-back beats need no
	// second assignment in the same step.
	task automatic send_beat(input grid_beat_t b, input verdict_src_e how);
		clear_verdict_t v;
		start      <= 1'b1;
		mode       <= b.mode;
		cell_row   <= b.row;
		cell_col   <= b.col;
		cell_value <= b.value;
		query_x    <= b.qx;
		query_y    <= b.qy;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (b.mode == MODE_WRITE) begin
			grid_shadow[{b.row, b.col}] = b.value;
			n_map_writes++;
		end else begin
			case (how)
				EXP_CLEAR:   v.is_clear = 1'b1;
				EXP_BLOCKED: v.is_clear = 1'b0;
				default:     v.is_clear = predict_clear(b.qx, b.qy);
			endcase
			v.query_no = n_queries;
			clear_verdicts_due.push_back(v);
			n_queries++;
		end
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending until every verdict is in and the block is idle, then let a few
	// cycles pass so a trailing map write has settled too.
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (clear_verdicts_due.size() != 0 || busy !== 1'b0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable drops on the next edge so calls can follow
	// each other without touching cfg_we twice in one step.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_ROWS: rows_reg = data[SIZE_W-1:0];
			REG_COLS: cols_reg = data[SIZE_W-1:0];
			REG_RAD:  rad_reg  = data[RAD_W-1:0];
			REG_THR:  thr_reg  = data[CELL_W-1:0];
			default: ;
		endcase
		n_reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Register value in the low bits, random junk above that the block must drop.
	function automatic logic [CFG_W-1:0] noisy(input int value, input int width);
		logic [CFG_W-1:0] mask;
		logic [CFG_W-1:0] junk;
		mask = (CFG_W'(1) << width) - 1'b1;
		junk = CFG_W'($urandom);
		return (junk & ~mask) | (CFG_W'(value) & mask);
	endfunction

	function automatic void dir_write(input int r, input int c, input int v);
		directed_row_t d;
		d            = '0;
		d.kind       = ROW_BEAT;
		d.how        = EXP_PREDICT;
		d.beat.mode  = MODE_WRITE;
		d.beat.row   = r[DIM_W-1:0];
		d.beat.col   = c[DIM_W-1:0];
		d.beat.value = v[CELL_W-1:0];
		directed_rows.push_back(d);
	endfunction

	function automatic void dir_query(input int x, input int y, input verdict_src_e how);
		directed_row_t d;
		d           = '0;
		d.kind      = ROW_BEAT;
		d.how       = how;
		d.beat.mode = MODE_QUERY;
		d.beat.qx   = x[Q_W-1:0];
		d.beat.qy   = y[Q_W-1:0];
		directed_rows.push_back(d);
	endfunction

	function automatic void dir_reg(input logic [IDX_W-1:0] idx, input int val);
		directed_row_t d;
		d         = '0;
		d.kind    = ROW_REG;
		d.how     = EXP_PREDICT;
		d.reg_idx = idx;
		d.reg_val = val[CFG_W-1:0];
		directed_rows.push_back(d);
	endfunction

	// Random beat aimed at where the action is: most writes land in a small hot
	// corner of the map and most queries are placed so their disk overlaps it,
	// the rest roam the whole field range.
	function automatic grid_beat_t random_beat();
		grid_beat_t b;
		longint     rows_n, cols_n, rad;
		int         off, hot_r, hot_c, tr, tc, fr, fc, pick;
		b.mode  = ($urandom_range(0, 99) < 45) ? MODE_WRITE : MODE_QUERY;
		b.row   = DIM_W'($urandom);
		b.col   = DIM_W'($urandom);
		b.value = CELL_W'($urandom);
		b.qx    = Q_W'($urandom);
		b.qy    = Q_W'($urandom);
		rows_n  = dim_in_use(rows_reg);
		cols_n  = dim_in_use(cols_reg);
		rad     = (rad_reg > RAD_MAX) ? RAD_MAX : rad_reg;
		off     = int'((rad + ONE - 1) / ONE);
		hot_r   = (rows_n < 24) ? int'(rows_n) : 24;
		hot_c   = (cols_n < 24) ? int'(cols_n) : 24;
		pick    = $urandom_range(0, 99);
		if (b.mode == MODE_WRITE) begin
			if (pick < 75) begin
				b.row = DIM_W'($urandom_range(0, hot_r + 1));
				b.col = DIM_W'($urandom_range(0, hot_c + 1));
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				b.value = '1;
			else if (pick < 70)
				b.value = CELL_W'($urandom_range(0, 100));
			else if (pick < 85)
				b.value = thr_reg + CELL_W'($urandom_range(0, 1));
		end else if (pick < 85) begin
			if ($urandom_range(0, 9) < 7) begin
				tr = int'($urandom_range(0, hot_r + 2 * off + 2)) - off - 1;
				tc = int'($urandom_range(0, hot_c + 2 * off + 2)) - off - 1;
			end else begin
				tr = int'($urandom_range(0, int'(rows_n) + 2 * off + 2)) - off - 1;
				tc = int'($urandom_range(0, int'(cols_n) + 2 * off + 2)) - off - 1;
			end
			// land on an exact half now and then to hit the rounding tie
			fr   = ($urandom_range(0, 9) == 0) ? HALF : int'($urandom_range(0, ONE - 1)) - HALF;
			fc   = ($urandom_range(0, 9) == 0) ? -HALF : int'($urandom_range(0, ONE - 1)) - HALF;
			b.qx = Q_W'(longint'(tr) * ONE + fr - (rows_n - 1) * HALF);
			b.qy = Q_W'(longint'(tc) * ONE + fc - (cols_n - 1) * HALF);
		end
		return b;
	endfunction

	// Pick and write one register setting per random phase. Early phases pin the
	// extremes, the big-radius phase drives the scan to its widest, the rest roam.
	task automatic program_phase(input int p);
		int rows_v, cols_v, rad_v, thr_v;
		rows_v = $urandom_range(1, 40);
		cols_v = $urandom_range(1, 40);
		rad_v  = $urandom_range(0, 1100);
		thr_v  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 101)) - 1
		                                    : int'($urandom_range(0, 255));
		case (p)
			0: begin
				rows_v = 1;
				cols_v = 1;
				rad_v  = $urandom_range(0, 512);
				thr_v  = 0;
			end
			1: begin
				rows_v = MAX_DIM;
				cols_v = MAX_DIM;
				rad_v  = 2048;
			end
			2: begin
				rows_v = 0;
				cols_v = $urandom_range(MAX_DIM + 1, 511);
				thr_v  = -1;
			end
			3: begin
				cols_v = MAX_DIM;
				rad_v  = 0;
				thr_v  = 100;
			end
			BIG_RAD_PHASE: begin
				rad_v = $urandom_range(0, 1) ? RAD_MAX : $urandom_range(RAD_MAX + 1, 8191);
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					rows_v = $urandom_range(0, 511);
			end
		endcase
		write_reg(REG_ROWS, noisy(rows_v, SIZE_W));
		write_reg(REG_COLS, noisy(cols_v, SIZE_W));
		write_reg(REG_RAD, CFG_W'(rad_v));
		write_reg(REG_THR, noisy(thr_v, CELL_W));
	endtask

	// Score each result beat against the oldest verdict waiting.
	always @(posedge clk) begin : check_results
		clear_verdict_t want;
		if (arst_n && done === 1'b1) begin
			if (clear_verdicts_due.size() == 0) begin
				report_mismatch($sformatf("result beat with no query waiting, is_clear=%b",
				                          is_clear));
			end else begin
				want = clear_verdicts_due.pop_front();
				if (is_clear !== want.is_clear)
					report_mismatch($sformatf("query %0d: is_clear=%b, predicted %b",
					                          want.query_no, is_clear, want.is_clear));
				if (want.is_clear)
					n_clear++;
				else
					n_blocked++;
			end
		end
	end

	initial begin : stimulus
		grid_beat_t b;
		int         a, phase, k, n_beats;
		logic       quiet;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Fill the whole store with "unknown" so no query can touch a cell that was
		// never written. Back to back, no idling: it is long enough as it is.
		b      = '0;
		b.mode = MODE_WRITE;
		for (a = 0; a < DEPTH; a++) begin
			b.row   = a[ADDR_W-1:DIM_W];
			b.col   = a[DIM_W-1:0];
			b.value = '1;
			send_beat(b, EXP_PREDICT);
		end

		// Directed table. Registers start at reset: full 256x256 map, radius of
		// 8 cells, threshold 0. The centre rounds to cell (128,128).
		dir_query(0, 0, EXP_CLEAR);              // only unknown cells
		dir_write(128, 128, 100);
		dir_query(0, 0, EXP_BLOCKED);
		dir_write(128, 128, 0);
		dir_query(0, 0, EXP_CLEAR);              // equal to threshold does not block
		dir_write(128, 128, 1);
		dir_query(0, 0, EXP_BLOCKED);            // one above threshold does
		dir_reg(REG_RAD, 0);
		dir_query(0, 0, EXP_CLEAR);              // zero radius holds no cell
		dir_reg(REG_RAD, 13'h1FFF);              // saturates to MAX_RADIUS
		dir_write(255, 255, 100);
		dir_query(32640, 32640, EXP_BLOCKED);    // far corner cell
		dir_write(255, 255, -1);
		dir_query(32640, 32640, EXP_CLEAR);
		dir_query(65535, 65535, EXP_CLEAR);      // disk wholly off the map
		dir_query(-65536, -65536, EXP_CLEAR);
		dir_reg(REG_THR, 13'h080);               // threshold -128: unknown blocks
		dir_query(0, 0, EXP_BLOCKED);
		dir_query(-65536, 0, EXP_CLEAR);
		dir_reg(REG_THR, 13'h07F);               // threshold 127: nothing can block
		dir_write(0, 0, 127);
		dir_query(-32640, -32640, EXP_CLEAR);
		dir_reg(REG_THR, 13'h0FF);               // threshold -1
		dir_query(-32640, -32640, EXP_BLOCKED);
		dir_reg(REG_ROWS, 0);                    // acts as one row
		dir_reg(REG_COLS, 13'h1FF);              // acts as MAX_DIM
		dir_write(5, 5, 100);                    // off the map, still stored
		dir_query(-128, -128, EXP_PREDICT);      // negative half rounds away
		dir_reg(REG_ROWS, 13'h1FF);
		dir_query(-31360, -31360, EXP_PREDICT);  // now lands on the stored cell
		dir_query(-128, 128, EXP_PREDICT);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_REG) begin
				wait_idle();
				write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
			end else begin
				if ($urandom_range(0, 2) == 0)
					hold_off($urandom_range(1, 16));
				send_beat(directed_rows[n].beat, directed_rows[n].how);
			end
		end

		// Random phases. Each opens with a full drain before its register writes;
		// idling comes in bursts during alternate stretches, and the last phase
		// runs flat out.
		for (phase = 0; phase < N_PHASES; phase++) begin
			wait_idle();
			program_phase(phase);
			n_beats = (phase == BIG_RAD_PHASE) ? BIG_RAD_BEATS : PHASE_BEATS;
			for (k = 0; k < n_beats; k++) begin
				quiet = ((k / 40) % 2 == 1) || (phase == N_PHASES - 1);
				if (!quiet && $urandom_range(0, 2) == 0)
					hold_off($urandom_range(1, 16));
				else if (!quiet && $urandom_range(0, 63) == 0)
					wait_idle();
				send_beat(random_beat(), EXP_PREDICT);
			end
		end

		// Drain: wait, within DRAIN_LIMIT, until every query is answered.
		start <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && clear_verdicts_due.size() != 0; k++)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (clear_verdicts_due.size() != 0)
			report_mismatch($sformatf("%0d queries never answered", clear_verdicts_due.size()));

		$display("Covered %0d map writes and %0d queries (%0d clear, %0d blocked)",
		         n_map_writes, n_queries, n_clear, n_blocked);
		$display("across %0d register writes and %0d random phases; %0d mismatches",
		         n_reg_writes, N_PHASES, n_mismatch);
		if (n_mismatch == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin : watchdog
		#200_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

[grid_disk_collision_check.f]
+incdir+design
design/gdcc_pkg.sv
design/gdcc_ram.sv
design/gdcc_sqr.sv
design/gdcc_seq.sv
design/grid_disk_collision_check.sv
test/tb_top.sv
